// ===== design/btcc_pkg.sv =====
// Shared types and constants for the battery temperature charge control block.
package btcc_pkg;

  localparam int TEMP_W     = 12;
  localparam int VOLT_W     = 23;
  localparam int CUR_W      = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 23;

  // Register reset values
  localparam logic signed [TEMP_W-1:0] COLD_LIMIT_RST   = -12'sd101;
  localparam logic signed [TEMP_W-1:0] COOL_LIMIT_RST   = -12'sd50;
  localparam logic signed [TEMP_W-1:0] NORMAL_LIMIT_RST = 12'sd419;
  localparam logic signed [TEMP_W-1:0] WARM_LIMIT_RST   = 12'sd450;
  localparam logic signed [TEMP_W-1:0] HOT_LIMIT_RST    = 12'sd550;
  localparam logic [VOLT_W-1:0]        VOLT_THRESH_RST  = 23'd4000000;
  localparam logic [CUR_W-1:0]         REDUCED_CUR_RST  = 12'd450;
  localparam logic [CUR_W-1:0]         DEFAULT_CUR_RST  = 12'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLD_LIMIT   = 3'd0,
    CFG_COOL_LIMIT   = 3'd1,
    CFG_NORMAL_LIMIT = 3'd2,
    CFG_WARM_LIMIT   = 3'd3,
    CFG_HOT_LIMIT    = 3'd4,
    CFG_VOLT_THRESH  = 3'd5,
    CFG_REDUCED_CUR  = 3'd6,
    CFG_DEFAULT_CUR  = 3'd7
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_NORMAL  = 2'd0,
    MODE_REDUCED = 2'd1,
    MODE_STOPPED = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    KIND_NONE              = 3'd0,
    KIND_NORMAL_TO_STOP    = 3'd1,
    KIND_NORMAL_TO_REDUCED = 3'd2,
    KIND_REDUCED_TO_STOP   = 3'd3,
    KIND_REDUCED_TO_NORMAL = 3'd4,
    KIND_STOP_TO_NORMAL    = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    ZONE_COLD     = 3'd0,
    ZONE_COOL     = 3'd1,
    ZONE_NORMAL   = 3'd2,
    ZONE_WARM     = 3'd3,
    ZONE_HOT      = 3'd4,
    ZONE_OVERHEAT = 3'd5
  } zone_t;

  typedef enum logic [1:0] {
    HEALTH_GOOD     = 2'd0,
    HEALTH_OVERHEAT = 2'd1,
    HEALTH_COLD     = 2'd2
  } health_t;

  // Classified sample handed from the front end to the state machine
  typedef struct packed {
    zone_t            zone;
    logic             over_volt;
    logic             present;
    logic             changed;
    logic [CUR_W-1:0] cur_normal;
    logic [CUR_W-1:0] cur_reduced;
  } item_t;

endpackage

// ===== design/battery_temperature_charge_control_top.sv =====
// Top level of the battery temperature charge control block.
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_stall   temperature, voltage, charger flags, limits
//   out_     output     out_valid / out_stall state, transition, currents, health, flags
//   cfg_     input      cfg_valid / cfg_ready register index and write data
//
// One sample is taken per cycle while in_stall is low; it passes the front end into a
// short queue and leaves through the output register, which is loaded when it is popped.
// The state machine steps per popped sample: one result per cycle without out_stall.
// rst_n is synchronous and active low; it empties the queue and output register.
// An output stall fills the queue; in_stall rises only when the queue is full.
module battery_temperature_charge_control_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [btcc_pkg::TEMP_W-1:0] in_battery_temp,
  input  logic [btcc_pkg::VOLT_W-1:0]       in_battery_voltage,
  input  logic                              in_charger_present,
  input  logic                              in_charger_changed,
  input  logic [btcc_pkg::CUR_W-1:0]        in_thermal_current_cap,
  input  logic [btcc_pkg::CUR_W-1:0]        in_max_charge_current,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        out_charge_state,
  output logic [2:0]                        out_transition_kind,
  output logic                              out_status_refresh,
  output logic                              out_disable_charge,
  output logic [btcc_pkg::CUR_W-1:0]        out_drive_current,
  output logic [1:0]                        out_health,
  output logic                              out_charging_indicator,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [btcc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [btcc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  btcc_pkg::item_t            front_item, q_item;
  logic [btcc_pkg::CUR_W-1:0] default_current;
  logic                       q_full, q_valid, q_pop, in_xfer;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign in_xfer   = in_valid && !q_full;

  btcc_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr              (cfg_valid && cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .battery_temp        (in_battery_temp),
    .battery_voltage     (in_battery_voltage),
    .charger_present     (in_charger_present),
    .charger_changed     (in_charger_changed),
    .thermal_current_cap (in_thermal_current_cap),
    .max_charge_current  (in_max_charge_current),
    .item                (front_item),
    .default_current     (default_current)
  );

  btcc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_xfer),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (q_item),
    .not_empty (q_valid)
  );

  btcc_back u_back (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .q_valid                (q_valid),
    .q_item                 (q_item),
    .q_pop                  (q_pop),
    .default_current        (default_current),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_charge_state       (out_charge_state),
    .out_transition_kind    (out_transition_kind),
    .out_status_refresh     (out_status_refresh),
    .out_disable_charge     (out_disable_charge),
    .out_drive_current      (out_drive_current),
    .out_health             (out_health),
    .out_charging_indicator (out_charging_indicator)
  );

endmodule

// ===== design/btcc_front.sv =====
// Front end: configuration registers, temperature zoning and current limit selection.
module btcc_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr,
  input  logic [btcc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [btcc_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic signed [btcc_pkg::TEMP_W-1:0] battery_temp,
  input  logic [btcc_pkg::VOLT_W-1:0]       battery_voltage,
  input  logic                              charger_present,
  input  logic                              charger_changed,
  input  logic [btcc_pkg::CUR_W-1:0]        thermal_current_cap,
  input  logic [btcc_pkg::CUR_W-1:0]        max_charge_current,
  output btcc_pkg::item_t                   item,
  output logic [btcc_pkg::CUR_W-1:0]        default_current
);

  logic signed [btcc_pkg::TEMP_W-1:0] cold_limit_r, cool_limit_r, normal_limit_r;
  logic signed [btcc_pkg::TEMP_W-1:0] warm_limit_r, hot_limit_r;
  logic [btcc_pkg::VOLT_W-1:0]        volt_thresh_r;
  logic [btcc_pkg::CUR_W-1:0]         reduced_cur_r;
  logic [btcc_pkg::CUR_W-1:0]         default_cur_r;
  btcc_pkg::zone_t                    zone;

  // Hold configuration; take a write transfer into the addressed register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cold_limit_r   <= btcc_pkg::COLD_LIMIT_RST;
      cool_limit_r   <= btcc_pkg::COOL_LIMIT_RST;
      normal_limit_r <= btcc_pkg::NORMAL_LIMIT_RST;
      warm_limit_r   <= btcc_pkg::WARM_LIMIT_RST;
      hot_limit_r    <= btcc_pkg::HOT_LIMIT_RST;
      volt_thresh_r  <= btcc_pkg::VOLT_THRESH_RST;
      reduced_cur_r  <= btcc_pkg::REDUCED_CUR_RST;
      default_cur_r  <= btcc_pkg::DEFAULT_CUR_RST;
    end else if (cfg_wr) begin
      case (btcc_pkg::cfg_idx_t'(cfg_index))
        btcc_pkg::CFG_COLD_LIMIT:   cold_limit_r   <= cfg_data[btcc_pkg::TEMP_W-1:0];
        btcc_pkg::CFG_COOL_LIMIT:   cool_limit_r   <= cfg_data[btcc_pkg::TEMP_W-1:0];
        btcc_pkg::CFG_NORMAL_LIMIT: normal_limit_r <= cfg_data[btcc_pkg::TEMP_W-1:0];
        btcc_pkg::CFG_WARM_LIMIT:   warm_limit_r   <= cfg_data[btcc_pkg::TEMP_W-1:0];
        btcc_pkg::CFG_HOT_LIMIT:    hot_limit_r    <= cfg_data[btcc_pkg::TEMP_W-1:0];
        btcc_pkg::CFG_VOLT_THRESH:  volt_thresh_r  <= cfg_data[btcc_pkg::VOLT_W-1:0];
        btcc_pkg::CFG_REDUCED_CUR:  reduced_cur_r  <= cfg_data[btcc_pkg::CUR_W-1:0];
        btcc_pkg::CFG_DEFAULT_CUR:  default_cur_r  <= cfg_data[btcc_pkg::CUR_W-1:0];
        default: ;
      endcase
    end
  end

  // Sort temperature into a zone, highest zone first; unordered limits fall to normal
  always_comb begin
    if (battery_temp > hot_limit_r)
      zone = btcc_pkg::ZONE_OVERHEAT;
    else if (battery_temp > warm_limit_r && battery_temp <= hot_limit_r)
      zone = btcc_pkg::ZONE_HOT;
    else if (battery_temp > normal_limit_r && battery_temp <= warm_limit_r)
      zone = btcc_pkg::ZONE_WARM;
    else if (battery_temp > cool_limit_r && battery_temp <= normal_limit_r)
      zone = btcc_pkg::ZONE_NORMAL;
    else if (battery_temp > cold_limit_r && battery_temp <= cool_limit_r)
      zone = btcc_pkg::ZONE_COOL;
    else if (battery_temp <= cold_limit_r)
      zone = btcc_pkg::ZONE_COLD;
    else
      zone = btcc_pkg::ZONE_NORMAL;
  end

  // Precompute the candidate currents and the voltage check
  always_comb begin
    item.zone        = zone;
    item.over_volt   = battery_voltage > volt_thresh_r;
    item.present     = charger_present;
    item.changed     = charger_changed;
    item.cur_normal  = (thermal_current_cap <= max_charge_current) ?
                       thermal_current_cap : max_charge_current;
    item.cur_reduced = (thermal_current_cap <= reduced_cur_r) ?
                       thermal_current_cap : reduced_cur_r;
  end

  assign default_current = default_cur_r;

endmodule

// ===== design/btcc_queue.sv =====
// Short queue of classified samples between front end and state machine.
module btcc_queue #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  btcc_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output btcc_pkg::item_t pop_item,
  output logic            not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  btcc_pkg::item_t   mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  count_r, count_nxt;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_item  = mem_r[rd_ptr_r];

  // Store a pushed entry
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  // Track occupancy
  always_comb begin
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  // Advance pointers with wrap at the depth
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push || pop)
    else $error("queue pushed while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("queue popped while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue occupancy above depth");
`endif

endmodule

// ===== design/btcc_back.sv =====
// Back end: charger state machine, status refresh tracking and the output register.
module btcc_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  input  btcc_pkg::item_t            q_item,
  output logic                       q_pop,
  input  logic [btcc_pkg::CUR_W-1:0] default_current,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 out_charge_state,
  output logic [2:0]                 out_transition_kind,
  output logic                       out_status_refresh,
  output logic                       out_disable_charge,
  output logic [btcc_pkg::CUR_W-1:0] out_drive_current,
  output logic [1:0]                 out_health,
  output logic                       out_charging_indicator
);

  btcc_pkg::mode_t   mode_r, mode_nxt, mode_eff;
  logic              last_charger_r, last_charger_nxt;
  logic              ind_r, ind_nxt;
  logic [btcc_pkg::CUR_W-1:0] last_cur_r;
  btcc_pkg::kind_t   kind;
  btcc_pkg::health_t health;
  logic [btcc_pkg::CUR_W-1:0] cur;
  logic              charger_event, insert_refresh, refresh_req;

  logic              out_valid_r;
  logic [1:0]        charge_state_r;
  logic [2:0]        kind_r;
  logic              refresh_r, disable_r, ind_out_r;
  logic [btcc_pkg::CUR_W-1:0] cur_r;
  logic [1:0]        health_r;

  // Take the next entry when the output register is free or being drained
  assign q_pop = q_valid && (!out_valid_r || !out_stall);

  // Charger attach or re-evaluation puts the machine back to normal
  always_comb begin
    charger_event    = (last_charger_r ^ q_item.present) || q_item.changed;
    last_charger_nxt = charger_event ? q_item.present : last_charger_r;
    insert_refresh   = charger_event && q_item.present;
    mode_eff         = insert_refresh ? btcc_pkg::MODE_NORMAL : mode_r;
  end

  // Next state, transition kind and indicator
  always_comb begin
    mode_nxt = mode_eff;
    ind_nxt  = ind_r;
    kind     = btcc_pkg::KIND_NONE;
    case (mode_eff)
      btcc_pkg::MODE_NORMAL: begin
        if (q_item.zone == btcc_pkg::ZONE_OVERHEAT || q_item.zone == btcc_pkg::ZONE_COLD) begin
          kind     = btcc_pkg::KIND_NORMAL_TO_STOP;
          ind_nxt  = (q_item.zone == btcc_pkg::ZONE_COLD);
          mode_nxt = btcc_pkg::MODE_STOPPED;
        end else if (q_item.zone == btcc_pkg::ZONE_HOT) begin
          if (q_item.over_volt) begin
            kind     = btcc_pkg::KIND_NORMAL_TO_STOP;
            ind_nxt  = 1'b1;
            mode_nxt = btcc_pkg::MODE_STOPPED;
          end else begin
            kind     = btcc_pkg::KIND_NORMAL_TO_REDUCED;
            ind_nxt  = 1'b0;
            mode_nxt = btcc_pkg::MODE_REDUCED;
          end
        end
      end
      btcc_pkg::MODE_REDUCED: begin
        if (q_item.zone == btcc_pkg::ZONE_OVERHEAT || q_item.zone == btcc_pkg::ZONE_COLD) begin
          kind     = btcc_pkg::KIND_REDUCED_TO_STOP;
          ind_nxt  = (q_item.zone == btcc_pkg::ZONE_COLD);
          mode_nxt = btcc_pkg::MODE_STOPPED;
        end else if (q_item.over_volt) begin
          kind     = btcc_pkg::KIND_REDUCED_TO_STOP;
          ind_nxt  = 1'b1;
          mode_nxt = btcc_pkg::MODE_STOPPED;
        end else if (q_item.zone inside {btcc_pkg::ZONE_COOL, btcc_pkg::ZONE_NORMAL}) begin
          kind     = btcc_pkg::KIND_REDUCED_TO_NORMAL;
          ind_nxt  = 1'b0;
          mode_nxt = btcc_pkg::MODE_NORMAL;
        end
      end
      btcc_pkg::MODE_STOPPED: begin
        if (q_item.zone == btcc_pkg::ZONE_NORMAL) begin
          kind     = btcc_pkg::KIND_STOP_TO_NORMAL;
          ind_nxt  = 1'b0;
          mode_nxt = btcc_pkg::MODE_NORMAL;
        end else if (q_item.zone == btcc_pkg::ZONE_OVERHEAT) begin
          ind_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // Drive current, health and status refresh for the new state
  always_comb begin
    case (mode_nxt)
      btcc_pkg::MODE_NORMAL:  cur = q_item.cur_normal;
      btcc_pkg::MODE_REDUCED: cur = q_item.cur_reduced;
      default:                cur = default_current;
    endcase
    case (q_item.zone)
      btcc_pkg::ZONE_OVERHEAT: health = btcc_pkg::HEALTH_OVERHEAT;
      btcc_pkg::ZONE_COLD:     health = btcc_pkg::HEALTH_COLD;
      default:                 health = btcc_pkg::HEALTH_GOOD;
    endcase
    refresh_req = insert_refresh || (last_cur_r != cur) || (ind_r != ind_nxt);
  end

  // Advance the machine state on each popped sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r         <= btcc_pkg::MODE_NORMAL;
      last_charger_r <= 1'b0;
      ind_r          <= 1'b0;
      last_cur_r     <= '0;
    end else if (q_pop) begin
      mode_r         <= mode_nxt;
      last_charger_r <= last_charger_nxt;
      ind_r          <= ind_nxt;
      last_cur_r     <= cur;
    end
  end

  // Hold the result until the downstream transfer completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      charge_state_r <= mode_nxt;
      kind_r         <= kind;
      refresh_r      <= refresh_req;
      disable_r      <= (mode_nxt == btcc_pkg::MODE_STOPPED);
      cur_r          <= cur;
      health_r       <= health;
      ind_out_r      <= ind_nxt;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_charge_state       = charge_state_r;
  assign out_transition_kind    = kind_r;
  assign out_status_refresh     = refresh_r;
  assign out_disable_charge     = disable_r;
  assign out_drive_current      = cur_r;
  assign out_health             = health_r;
  assign out_charging_indicator = ind_out_r;

`ifndef SYNTH
  a_pop_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> out_valid_r)
    else $error("popped sample did not reach the output register");

  a_ind_change_refreshes: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && (ind_nxt != ind_r) |=> out_status_refresh)
    else $error("indicator change without status refresh");

  a_resume_from_stop: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && (kind == btcc_pkg::KIND_STOP_TO_NORMAL) |->
      (mode_r == btcc_pkg::MODE_STOPPED) && !insert_refresh)
    else $error("resume from stop without a stopped state");
`endif

endmodule
